// ===== rtl/wpht_pkg.sv =====
// shared types, constants, weight table and control store of the pitch/height tracker
`timescale 1ns / 1ps

package wpht_pkg;

  localparam int HIST_DEPTH_DEF   = 3;
  localparam int DATA_W           = 16;
  localparam int WEIGHT_W         = 16;
  localparam int WPROD_W          = 32;
  localparam int PROD_W           = 48;
  localparam int QUOT_W           = 17;
  localparam int STEP_W           = 4;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // control store addresses
  localparam logic [STEP_W-1:0] ST_WAIT    = 4'd0;
  localparam logic [STEP_W-1:0] ST_INIT    = 4'd1;
  localparam logic [STEP_W-1:0] ST_MULW    = 4'd2;
  localparam logic [STEP_W-1:0] ST_MULV    = 4'd3;
  localparam logic [STEP_W-1:0] ST_ACC     = 4'd4;
  localparam logic [STEP_W-1:0] ST_DIVH_LD = 4'd5;
  localparam logic [STEP_W-1:0] ST_DIVH    = 4'd6;
  localparam logic [STEP_W-1:0] ST_DIVP_LD = 4'd7;
  localparam logic [STEP_W-1:0] ST_DIVP    = 4'd8;
  localparam logic [STEP_W-1:0] ST_SAVEP   = 4'd9;
  localparam logic [STEP_W-1:0] ST_FINISH  = 4'd10;
  localparam logic [STEP_W-1:0] ST_RETRY   = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_INIT,
    OP_MULW,
    OP_MULV,
    OP_ACC,
    OP_DIVH_LOAD,
    OP_DIV_STEP,
    OP_DIVP_LOAD,
    OP_SAVEP,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_SKIP_MAC,
    C_MORE_AGES,
    C_ZERO_WSUM,
    C_DIV_BUSY,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t                op;
    cond_t              cond;
    logic [STEP_W-1:0]  target;
  } ucw_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // sqrt(2)^-age in Q1.15, rounded
  function automatic logic [WEIGHT_W-1:0] age_weight(input logic [3:0] age);
    logic [WEIGHT_W-1:0] w;
    case (age)
      4'd0:    w = 16'd32768;
      4'd1:    w = 16'd23170;
      4'd2:    w = 16'd16384;
      4'd3:    w = 16'd11585;
      4'd4:    w = 16'd8192;
      4'd5:    w = 16'd5793;
      4'd6:    w = 16'd4096;
      4'd7:    w = 16'd2896;
      4'd8:    w = 16'd2048;
      4'd9:    w = 16'd1448;
      4'd10:   w = 16'd1024;
      4'd11:   w = 16'd724;
      4'd12:   w = 16'd512;
      4'd13:   w = 16'd362;
      4'd14:   w = 16'd256;
      default: w = 16'd181;
    endcase
    return w;
  endfunction

  // control program: jump to target when cond holds, else fall through
  function automatic ucw_t ucode(input logic [STEP_W-1:0] step);
    ucw_t u;
    case (step)
      ST_WAIT:    u = '{OP_WAIT,      C_NO_ITEM,   ST_WAIT};
      ST_INIT:    u = '{OP_INIT,      C_SKIP_MAC,  ST_FINISH};
      ST_MULW:    u = '{OP_MULW,      C_NEVER,     ST_WAIT};
      ST_MULV:    u = '{OP_MULV,      C_NEVER,     ST_WAIT};
      ST_ACC:     u = '{OP_ACC,       C_MORE_AGES, ST_MULW};
      ST_DIVH_LD: u = '{OP_DIVH_LOAD, C_ZERO_WSUM, ST_FINISH};
      ST_DIVH:    u = '{OP_DIV_STEP,  C_DIV_BUSY,  ST_DIVH};
      ST_DIVP_LD: u = '{OP_DIVP_LOAD, C_NEVER,     ST_WAIT};
      ST_DIVP:    u = '{OP_DIV_STEP,  C_DIV_BUSY,  ST_DIVP};
      ST_SAVEP:   u = '{OP_SAVEP,     C_NEVER,     ST_WAIT};
      ST_FINISH:  u = '{OP_FINISH,    C_OUT_FREE,  ST_WAIT};
      ST_RETRY:   u = '{OP_NOP,       C_ALWAYS,    ST_FINISH};
      default:    u = '{OP_NOP,       C_ALWAYS,    ST_WAIT};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/wpht_div.sv =====
// bit-serial restoring divider, one quotient bit per step
`timescale 1ns / 1ps

module wpht_div
  import wpht_pkg::*;
#(
  parameter int DEN_W = WPROD_W + 2
) (
  input  logic                      clk,
  input  div_ctrl_t                 ctrl,
  input  logic [DEN_W+QUOT_W-2:0]   num,
  input  logic [DEN_W-1:0]          den,
  output logic [QUOT_W-1:0]         quot
);

  localparam int NUM_W = DEN_W + QUOT_W - 1;

  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dsh;
  logic              fits;

  // quotient is known to stay below 2^QUOT_W
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem  <= num;
      dsh  <= {den, {(QUOT_W-1){1'b0}}};
      quot <= '0;
    end else if (ctrl.step) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh  <= dsh >> 1;
      quot <= {quot[QUOT_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/weighted_pitch_height_tracker.sv =====
// top level: pitch/height history with weighted average, run by a microcoded sequencer
`timescale 1ns / 1ps

// Holds the last HIST_DEPTH (pitch, height, inlier ratio) entries, newest first, and
// answers every input transfer with one result: the inlier- and age-weighted average of
// the stored pitch and height, the entry count and a valid flag. s_tuser selects the
// item kind (push then read, read only, clear; code 3 reads). A small control program
// steps one shared datapath: per held entry it forms the weight, then the two products,
// then accumulates; then one bit-serial divider computes height and then pitch. An empty
// history or a depth of one skips the entry loop and the divider; a zero weight sum
// skips the divider. A stalled result keeps the sequencer looping through its finish and
// retry steps until the output register is free. Inputs are taken only while the
// sequencer waits at its first step; a finished result sits in an output register, so
// the next item is taken while it waits.
module weighted_pitch_height_tracker
  import wpht_pkg::*;
#(
  parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pitch_in[15:0], height_in[31:16], inlier_frac[47:32]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // avg_pitch[15:0], avg_height[31:16], fill_count[33:32], zeros
  output logic [0:0]  m_tuser    // valid_res[0]
);

  localparam int CNT_W = $clog2(HIST_DEPTH + 1);
  localparam int AGE_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int SW_W  = WPROD_W + CNT_W;            // weight sum
  localparam int NUM_W = PROD_W + CNT_W;             // value sums and divider numerator

  // history, index is age, 0 = newest
  logic [DATA_W-1:0] hist_pitch  [HIST_DEPTH];
  logic [DATA_W-1:0] hist_height [HIST_DEPTH];
  logic [DATA_W-1:0] hist_inlier [HIST_DEPTH];
  logic [CNT_W-1:0]  held;

  // sequencer
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucw_t              uw;
  logic              jump;
  logic [4:0]        div_cnt;

  // datapath
  logic [AGE_W-1:0]         age;
  logic [WPROD_W-1:0]       wreg;
  logic signed [PROD_W-1:0] prod_p;
  logic [PROD_W-1:0]        prod_h;
  logic [SW_W-1:0]          sum_w;
  logic signed [NUM_W-1:0]  sum_p;
  logic [NUM_W-1:0]         sum_h;
  logic [NUM_W-1:0]         mag_p;
  logic                     neg_p;
  logic [DATA_W-1:0]        avg_p;
  logic [DATA_W-1:0]        avg_h;
  logic                     res_valid;
  logic [QUOT_W-1:0]        quot;
  div_ctrl_t                div_ctrl;
  logic [NUM_W-1:0]         div_num;

  logic       in_xfer;
  logic       out_load;
  logic       skip_mac;
  logic       more_ages;
  logic [1:0] kind;

  assign kind     = s_tuser;
  assign uw       = ucode(step);
  assign s_tready = (uw.op == OP_WAIT);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_load = (uw.op == OP_FINISH) && (!m_tvalid || m_tready);

  assign skip_mac  = (held == '0) || (HIST_DEPTH == 1);
  assign more_ages = ((CNT_W'(age) + CNT_W'(1)) < held);

  // jump condition select
  always_comb begin
    case (uw.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_ITEM:   jump = !in_xfer;
      C_SKIP_MAC:  jump = skip_mac;
      C_MORE_AGES: jump = more_ages;
      C_ZERO_WSUM: jump = (sum_w == '0);
      C_DIV_BUSY:  jump = (div_cnt != 5'd0);
      C_OUT_FREE:  jump = !m_tvalid || m_tready;
      default:     jump = 1'b0;
    endcase
    step_next = jump ? uw.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // history update on an input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (in_xfer) begin
      if (kind == KIND_PUSH) begin
        if (held != CNT_W'(HIST_DEPTH)) begin
          held <= held + CNT_W'(1);
        end
      end else if (kind == KIND_CLEAR) begin
        held <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && kind == KIND_PUSH) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        hist_pitch[i]  <= hist_pitch[i-1];
        hist_height[i] <= hist_height[i-1];
        hist_inlier[i] <= hist_inlier[i-1];
      end
      hist_pitch[0]  <= s_tdata[15:0];
      hist_height[0] <= s_tdata[31:16];
      hist_inlier[0] <= s_tdata[47:32];
    end
  end

  // divider feed: height first, then pitch magnitude
  assign neg_p   = sum_p[NUM_W-1];
  assign mag_p   = neg_p ? NUM_W'(-sum_p) : NUM_W'(sum_p);
  assign div_num = (uw.op == OP_DIVH_LOAD) ? sum_h : mag_p;
  assign div_ctrl.load = (uw.op == OP_DIVH_LOAD) || (uw.op == OP_DIVP_LOAD);
  assign div_ctrl.step = (uw.op == OP_DIV_STEP);

  wpht_div #(
    .DEN_W (SW_W)
  ) u_div (
    .clk  (clk),
    .ctrl (div_ctrl),
    .num  (div_num),
    .den  (sum_w),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= 5'd0;
    end else if (div_ctrl.load) begin
      div_cnt <= 5'(QUOT_W - 1);
    end else if (div_ctrl.step && div_cnt != 5'd0) begin
      div_cnt <= div_cnt - 5'd1;
    end
  end

  // shared multiply-accumulate datapath
  always_ff @(posedge clk) begin
    case (uw.op)
      OP_INIT: begin
        age   <= '0;
        sum_w <= '0;
        sum_p <= '0;
        sum_h <= '0;
        if (held != '0 && HIST_DEPTH == 1) begin
          // single entry passes through whatever its inlier ratio
          avg_p     <= hist_pitch[0];
          avg_h     <= hist_height[0];
          res_valid <= 1'b1;
        end else begin
          avg_p     <= '0;
          avg_h     <= '0;
          res_valid <= 1'b0;
        end
      end
      OP_MULW: begin
        wreg <= WPROD_W'(hist_inlier[age]) * WPROD_W'(age_weight(4'(age)));
      end
      OP_MULV: begin
        prod_p <= $signed(PROD_W'($signed(hist_pitch[age])))
                  * $signed(PROD_W'({1'b0, wreg}));
        prod_h <= PROD_W'(hist_height[age]) * PROD_W'(wreg);
      end
      OP_ACC: begin
        sum_w <= sum_w + SW_W'(wreg);
        sum_p <= sum_p + NUM_W'(prod_p);
        sum_h <= sum_h + NUM_W'(prod_h);
        if (more_ages) begin
          age <= age + AGE_W'(1);
        end
      end
      OP_DIVP_LOAD: begin
        avg_h <= quot[DATA_W-1:0];
      end
      OP_SAVEP: begin
        avg_p     <= neg_p ? (~quot[DATA_W-1:0] + DATA_W'(1)) : quot[DATA_W-1:0];
        res_valid <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, 2'(held), avg_h, avg_p};
      m_tuser <= res_valid;
    end
  end

`ifndef NO_ASSERTIONS
  // entry count never runs past the history depth
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(HIST_DEPTH))
    else $error("history count beyond depth");

  // an empty history never reports a valid average
  a_empty_invalid: assert property (@(posedge clk) disable iff (rst)
    (out_load && held == '0) |=> !m_tuser[0])
    else $error("valid result from empty history");

  // divider step count stays within one quotient
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    div_cnt <= 5'(QUOT_W - 1))
    else $error("divider step count out of range");

  // for depths below four, a valid result always shows a nonzero fill count
  a_valid_fill: assert property (@(posedge clk) disable iff (rst)
    (HIST_DEPTH < 4 && m_tvalid && m_tuser[0]) |-> m_tdata[33:32] != 2'd0)
    else $error("valid result with zero fill count");

  // the divider only runs after a nonzero weight sum was found
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.step |-> sum_w != '0)
    else $error("divider running on zero weight sum");
`endif

endmodule
